// File: sv/lxtd_pkg.sv
package lxtd_pkg;

  localparam int unsigned WORD_W    = 32;
  localparam int unsigned PROD_W    = 2 * WORD_W;
  localparam int unsigned CHAR_W    = 8;
  localparam int unsigned IDX_W     = 2;
  localparam int unsigned MUL_STEPS = WORD_W;
  localparam int unsigned DIV_STEPS = PROD_W;
  localparam int unsigned CNT_W     = $clog2(DIV_STEPS);

  localparam logic [WORD_W-1:0] MULT_RST = 32'd16811;
  localparam logic [WORD_W-1:0] INC_RST  = 32'd7;
  localparam logic [WORD_W-1:0] MOD_RST  = 32'd2147483647;

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_UPPER = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_LOWER = 8'h61;

  typedef enum logic [IDX_W-1:0] {
    REG_MULT = 2'd0,
    REG_INC  = 2'd1,
    REG_MOD  = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_FIN
  } st_t;

  function automatic logic is_space(input logic [CHAR_W-1:0] c);
    return (c >= 8'h09 && c <= 8'h0D) || c == 8'h20;
  endfunction

  function automatic logic is_letter(input logic [CHAR_W-1:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
  endfunction

  function automatic logic [CHAR_W-1:0] times_ten(input logic [CHAR_W-1:0] v);
    return (v << 3) + (v << 1);
  endfunction

endpackage

// File: sv/lxtd_if.sv
interface lxtd_text_if import lxtd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] text_char;
  logic              message_start;
  logic              message_end;

  modport source(output valid, text_char, message_start, message_end, input ready);
  modport sink(input valid, text_char, message_start, message_end, output ready);
endinterface

interface lxtd_plain_if import lxtd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] plain_byte;
  logic              corrupted;

  modport source(output valid, plain_byte, corrupted, input ready);
  modport sink(input valid, plain_byte, corrupted, output ready);
endinterface

interface lxtd_cfg_if import lxtd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [IDX_W-1:0]  index;
  logic [WORD_W-1:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// File: sv/lcg_xor_text_decoder.sv
// A character that steps the generator is decoded through the bit-serial multiplier
// (ST_MUL), the restoring reduction (ST_DIV, skipped with a zero modulus) and ST_FIN,
// and its byte, if nonzero, is then presented on the output. Throughput: one character
// per cycle when no step is needed; a stepping character holds off input until ST_FIN
// is done, and the finish cycle holds while a result beat waits on the output.
// Reset (synchronous, rst high) loads the register defaults and clears message state.
module lcg_xor_text_decoder import lxtd_pkg::*; (
  input logic         clk,
  input logic         rst,
  lxtd_text_if.sink   text,
  lxtd_plain_if.source plain,
  lxtd_cfg_if.sink    cfg
);

  st_t state, state_next;
  logic [CNT_W-1:0] cnt;

  logic [WORD_W-1:0] mult, inc, modulus;

  logic [WORD_W-1:0] seed;
  logic              seed_taken;
  logic [CHAR_W-1:0] pend_low;
  logic              pend_valid;
  logic              term;

  logic [PROD_W-1:0] prod;
  logic [WORD_W-1:0] rem;
  logic [CHAR_W-1:0] byte_hold;
  logic              bad_hold;
  logic              end_hold;

  logic              out_valid;
  logic [CHAR_W-1:0] out_byte;
  logic              out_bad;

  logic in_acc, fin_fire, mul_last, div_last;

  // decode results at accept time
  logic [WORD_W-1:0] seed_a;
  logic              taken_a, pv_a, term_a, take, bad, launch;
  logic [CHAR_W-1:0] pl_a, dec_byte, high;

  logic [WORD_W:0]   mul_sum;
  logic [WORD_W:0]   div_shift;
  logic [WORD_W:0]   div_diff;
  logic [WORD_W-1:0] result;
  logic [CHAR_W-1:0] plain_val;

  assign in_acc   = text.valid && text.ready;
  assign fin_fire = (state == ST_FIN) && (!out_valid || plain.ready);
  assign mul_last = cnt == CNT_W'(MUL_STEPS - 1);
  assign div_last = cnt == CNT_W'(DIV_STEPS - 1);

  always_comb begin
    taken_a  = text.message_start ? 1'b0 : seed_taken;
    term_a   = text.message_start ? 1'b0 : term;
    pv_a     = text.message_start ? 1'b0 : pend_valid;
    pl_a     = text.message_start ? '0 : pend_low;
    seed_a   = text.message_start ? '0 : seed;
    take     = 1'b0;
    bad      = 1'b0;
    dec_byte = '0;
    high     = '0;
    launch   = 1'b0;
    if (!is_space(text.text_char)) begin
      if (pv_a) begin
        high     = pl_a[0] ? text.text_char - CHAR_UPPER : text.text_char - CHAR_LOWER;
        dec_byte = times_ten(high) + pl_a;
        take     = 1'b1;
        pv_a     = 1'b0;
        pl_a     = '0;
      end else if (is_letter(text.text_char)) begin
        dec_byte = text.text_char;
        take     = 1'b1;
      end else begin
        pl_a = text.text_char - CHAR_ZERO;
        pv_a = 1'b1;
      end
    end
    // lone digit at end of message: use the raw character
    if (text.message_end && pv_a && !take) begin
      dec_byte = pl_a + CHAR_ZERO;
      bad      = 1'b1;
      take     = 1'b1;
      pv_a     = 1'b0;
    end
    if (take) begin
      if (!taken_a) begin
        seed_a  = {{(WORD_W-CHAR_W){1'b0}}, dec_byte};
        taken_a = 1'b1;
      end else if (!term_a) begin
        launch = 1'b1;
      end
    end
    if (text.message_end) begin
      seed_a  = '0;
      taken_a = 1'b0;
      pv_a    = 1'b0;
      pl_a    = '0;
      term_a  = 1'b0;
    end
  end

  always_comb begin
    mul_sum   = {1'b0, prod[PROD_W-1:WORD_W]} + (prod[0] ? {1'b0, mult} : '0);
    div_shift = {rem, prod[PROD_W-1]};
    div_diff  = div_shift - {1'b0, modulus};
    result    = (modulus == '0) ? prod[WORD_W-1:0] : rem;
    plain_val = byte_hold ^ result[CHAR_W-1:0];
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (in_acc && launch) state_next = ST_MUL;
      ST_MUL:  if (mul_last) state_next = (modulus == '0) ? ST_FIN : ST_DIV;
      ST_DIV:  if (div_last) state_next = ST_FIN;
      ST_FIN:  if (fin_fire) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    text.ready       = state == ST_IDLE;
    cfg.ready        = 1'b1;
    plain.valid      = out_valid;
    plain.plain_byte = out_byte;
    plain.corrupted  = out_bad;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      cnt        <= '0;
      mult       <= MULT_RST;
      inc        <= INC_RST;
      modulus    <= MOD_RST;
      seed       <= '0;
      seed_taken <= 1'b0;
      pend_low   <= '0;
      pend_valid <= 1'b0;
      term       <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg.valid && cfg.ready) begin
        case (reg_idx_t'(cfg.index))
          REG_MULT: mult    <= cfg.data;
          REG_INC:  inc     <= cfg.data;
          REG_MOD:  modulus <= cfg.data;
          default:  ;
        endcase
      end
      if (in_acc) begin
        seed       <= seed_a;
        seed_taken <= taken_a;
        pend_low   <= pl_a;
        pend_valid <= pv_a;
        term       <= term_a;
      end
      if (state == ST_MUL || state == ST_DIV) begin
        cnt <= (mul_last && state == ST_MUL) || div_last ? '0 : cnt + 1'b1;
      end else begin
        cnt <= '0;
      end
      if (fin_fire && plain_val != '0) begin
        out_valid <= 1'b1;
      end else if (plain.ready) begin
        out_valid <= 1'b0;
      end
      if (fin_fire) begin
        // the message closed with this byte: drop the stepped seed
        if (!end_hold) begin
          seed <= result;
          if (plain_val == '0) term <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_acc && launch) begin
          // preload the increment so the shift-add yields seed*mult + inc
          prod      <= {inc, seed};
          rem       <= '0;
          byte_hold <= dec_byte;
          bad_hold  <= bad;
          end_hold  <= text.message_end;
        end
      end
      ST_MUL: prod <= {mul_sum, prod[WORD_W-1:1]};
      ST_DIV: begin
        prod <= {prod[PROD_W-2:0], 1'b0};
        rem  <= div_diff[WORD_W] ? div_shift[WORD_W-1:0] : div_diff[WORD_W-1:0];
      end
      ST_FIN: begin
        if (fin_fire) begin
          out_byte <= plain_val;
          out_bad  <= bad_hold;
        end
      end
      default: ;
    endcase
  end

endmodule

// File: sv/lxtd_chk.sv
module lxtd_chk import lxtd_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [CHAR_W-1:0] out_byte,
  input logic              out_corrupted,
  input logic              cfg_ready
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_byte) && $stable(out_corrupted))
    else $error("stalled result beat changed");

  a_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_byte != '0)
    else $error("zero byte delivered");

  a_no_quick_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("result appeared one cycle after a character");

  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_ready)
    else $error("configuration port stalled");

endmodule

bind lcg_xor_text_decoder lxtd_chk u_lxtd_chk (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (text.valid),
  .in_ready     (text.ready),
  .out_valid    (plain.valid),
  .out_ready    (plain.ready),
  .out_byte     (plain.plain_byte),
  .out_corrupted(plain.corrupted),
  .cfg_ready    (cfg.ready)
);
